// ===== hw/rtl/tatm_pkg.sv =====
// Package with the types and fixed constants of the tilt trimmed-mean block.
package tatm_pkg;

    localparam int SampleW = 20;
    localparam int RootInW = 50;    // (d1^2 + d2^2) << 8 fits in 50 bits
    localparam int RootW   = 25;
    localparam int CordW   = 28;    // signed CORDIC datapath width
    localparam int AngW    = 24;    // signed angle accumulator, degrees * 65536
    localparam int TiltW   = 16;
    localparam int SumW    = 22;
    localparam int AngleLimit = 23040;

    typedef logic signed [SampleW-1:0] sample_t;
    typedef logic signed [TiltW-1:0]   tilt_t;

    typedef struct packed {
        logic  start;
        logic  busy;
        logic  done;
        tilt_t angle;
    } tilt_ctl_t;

    function automatic logic [AngW-1:0] atan_deg(input logic [4:0] i);
        logic [AngW-1:0] v;
        begin
            case (i)
                5'd0:  v = 24'd2949120;
                5'd1:  v = 24'd1740967;
                5'd2:  v = 24'd919879;
                5'd3:  v = 24'd466945;
                5'd4:  v = 24'd234379;
                5'd5:  v = 24'd117304;
                5'd6:  v = 24'd58666;
                5'd7:  v = 24'd29335;
                5'd8:  v = 24'd14668;
                5'd9:  v = 24'd7334;
                5'd10: v = 24'd3667;
                5'd11: v = 24'd1833;
                5'd12: v = 24'd917;
                5'd13: v = 24'd458;
                5'd14: v = 24'd229;
                5'd15: v = 24'd115;
                5'd16: v = 24'd57;
                5'd17: v = 24'd29;
                5'd18: v = 24'd14;
                5'd19: v = 24'd7;
                5'd20: v = 24'd4;
                5'd21: v = 24'd2;
                5'd22: v = 24'd1;
                default: v = 24'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hw/rtl/tatm_tilt.sv =====
// One tilt angle: serial squaring, digit-by-digit root, iterative CORDIC vectoring.
module tatm_tilt #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tatm_pkg::sample_t    num,
    input  tatm_pkg::sample_t    d1,
    input  tatm_pkg::sample_t    d2,
    output tatm_pkg::tilt_ctl_t  ctl
);

    localparam int RW = tatm_pkg::RootInW;
    localparam int CW = tatm_pkg::CordW;
    localparam int AW = tatm_pkg::AngW;
    localparam int SW = tatm_pkg::SampleW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQR  = 5'b00010,
        S_ROOT = 5'b00100,
        S_CORD = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] cnt_reg;

    // Magnitudes of the two denominator axes, squared bit-serially.
    logic [SW-1:0] m1_reg, m2_reg;
    logic [SW-1:0] mul1_reg, mul2_reg;
    logic [RW-1:0] acc_reg;
    logic          sq_zero_reg;

    logic [RW-1:0] rem_reg;
    logic [tatm_pkg::RootW-1:0] root_reg;

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [AW-1:0] z_reg;
    logic signed [SW-1:0] num_reg;
    tatm_pkg::tilt_t      angle_reg;

    logic [SW-1:0] abs1, abs2;
    assign abs1 = d1[SW-1] ? SW'(-d1) : SW'(d1);
    assign abs2 = d2[SW-1] ? SW'(-d2) : SW'(d2);

    // One multiplier bit per cycle, MSB first, for both squares.
    logic [RW-1:0] sq_step;
    assign sq_step = (acc_reg << 1)
                   + (mul1_reg[SW-1] ? RW'(m1_reg) : RW'(0))
                   + (mul2_reg[SW-1] ? RW'(m2_reg) : RW'(0));

    // Root step: two radicand bits per cycle.
    logic [RW-1:0]                 rem_sh;
    logic [tatm_pkg::RootW+1:0]    trial;
    logic [RW-1:0]                 trial_ext;
    assign rem_sh    = {rem_reg[RW-3:0], 2'b00} | RW'(acc_reg[RW-1:RW-2]);
    assign trial     = {root_reg, 2'b01};
    assign trial_ext = RW'(trial);

    logic signed [CW-1:0] xs, ys;
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;

    logic signed [AW-1:0] z_round;
    assign z_round = (z_reg + AW'(128)) >>> 8;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_SQR;
            S_SQR:  if (cnt_reg == 5'(SW-1)) state_next = S_ROOT;
            S_ROOT: if (cnt_reg == 5'(tatm_pkg::RootW-1)) state_next = S_CORD;
            S_CORD: if (cnt_reg == 5'(CORDIC_STEPS-1)) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                m1_reg   <= abs1;
                m2_reg   <= abs2;
                mul1_reg <= abs1;
                mul2_reg <= abs2;
                acc_reg  <= '0;
                num_reg  <= num;
            end
            S_SQR:
            begin
                mul1_reg <= mul1_reg << 1;
                mul2_reg <= mul2_reg << 1;
                if (cnt_reg == 5'(SW-1))
                begin
                    // Scale by 256 on the way into the root.
                    acc_reg     <= sq_step << 8;
                    sq_zero_reg <= (sq_step == '0);
                    rem_reg     <= '0;
                    root_reg    <= '0;
                end
                else
                    acc_reg <= sq_step;
            end
            S_ROOT:
            begin
                acc_reg <= acc_reg << 2;
                if (rem_sh >= trial_ext)
                begin
                    rem_reg  <= rem_sh - trial_ext;
                    root_reg <= {root_reg[tatm_pkg::RootW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[tatm_pkg::RootW-2:0], 1'b0};
                end
                if (cnt_reg == 5'(tatm_pkg::RootW-1))
                begin
                    z_reg <= '0;
                    y_reg <= CW'(num_reg) <<< 4;
                end
            end
            S_CORD:
            begin
                if (!y_reg[CW-1])
                begin
                    x_reg <= (cnt_reg == 5'd0 ? CW'({1'b0, root_reg}) : x_reg) + ys;
                    y_reg <= y_reg - (cnt_reg == 5'd0 ? CW'({1'b0, root_reg}) : xs);
                    z_reg <= z_reg + tatm_pkg::atan_deg(cnt_reg);
                end
                else
                begin
                    x_reg <= (cnt_reg == 5'd0 ? CW'({1'b0, root_reg}) : x_reg) - ys;
                    y_reg <= y_reg + (cnt_reg == 5'd0 ? CW'({1'b0, root_reg}) : xs);
                    z_reg <= z_reg - tatm_pkg::atan_deg(cnt_reg);
                end
            end
            S_DONE:
            begin
                if (sq_zero_reg)
                    angle_reg <= num_reg[SW-1] ? tatm_pkg::tilt_t'(-tatm_pkg::AngleLimit)
                               : (num_reg == '0) ? '0
                               : tatm_pkg::tilt_t'(tatm_pkg::AngleLimit);
                else if (z_round > AW'(tatm_pkg::AngleLimit))
                    angle_reg <= tatm_pkg::tilt_t'(tatm_pkg::AngleLimit);
                else if (z_round < -AW'(tatm_pkg::AngleLimit))
                    angle_reg <= tatm_pkg::tilt_t'(-tatm_pkg::AngleLimit);
                else
                    angle_reg <= tatm_pkg::tilt_t'(z_round);
            end
            default: ;
        endcase
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == S_DONE);
    end

    assign ctl.start = start;
    assign ctl.busy  = (state_reg != S_IDLE);
    assign ctl.done  = done_reg;
    assign ctl.angle = angle_reg;

`ifndef SYNTH
    a_done_after_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> done_reg) else $error("done pulse missing");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held for two cycles");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_SQR))
        else $error("start not taken");
`endif

endmodule

// ===== hw/rtl/tilt_angle_trimmed_mean.sv =====
// Top level: two tilt units, window sums and extremes, serial trimmed-mean division.
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | raw_x, raw_y, raw_z
//  out     | output    | out_valid/out_stall| tilt_x_mean, tilt_y_mean
// Each word passes through the serial squarer, the radix-4 root
// and the CORDIC loop of each tilt unit.
// The last word of a window adds a restoring division for the mean,
// and the division holds while the previous result is still unaccepted.
// Reset clears the window state at once; no clearing pass is needed.
// While a result waits under out_stall the next word is still taken and worked on.
module tilt_angle_trimmed_mean #(
    parameter int WINDOW_SIZE  = 20,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] raw_x,
    input  logic [23:0] raw_y,
    input  logic [23:0] raw_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] tilt_x_mean,
    output logic signed [15:0] tilt_y_mean
);

    localparam int SumW = tatm_pkg::SumW;
    localparam int CntW = $clog2(WINDOW_SIZE + 1);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_WORK = 4'b0010,
        T_DIV  = 4'b0100,
        T_HOLD = 4'b1000
    } top_state_t;

    top_state_t state_reg;
    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    tatm_pkg::sample_t ax, ay, az;
    assign ax = raw_x[23:4];
    assign ay = raw_y[23:4];
    assign az = raw_z[23:4];

    tatm_pkg::tilt_ctl_t cx, cy;
    tatm_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt_x (
        .clk(clk), .rst_n(rst_n), .start(in_acc), .num(ax), .d1(ay), .d2(az), .ctl(cx));
    tatm_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt_y (
        .clk(clk), .rst_n(rst_n), .start(in_acc), .num(ay), .d1(ax), .d2(az), .ctl(cy));

    logic signed [SumW-1:0] sum_x_reg, sum_y_reg;
    tatm_pkg::tilt_t lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic [CntW-1:0] count_reg;

    // Restoring division of |trimmed sum| by WINDOW_SIZE-2, one quotient bit a cycle.
    logic [SumW-1:0] dx_reg, dy_reg, rx_reg, ry_reg;
    logic            nx_reg, ny_reg;
    logic [4:0]      dcnt_reg;
    logic signed [SumW-1:0] tx_sum, ty_sum;
    assign tx_sum = sum_x_reg - SumW'(lo_x_reg) - SumW'(hi_x_reg);
    assign ty_sum = sum_y_reg - SumW'(lo_y_reg) - SumW'(hi_y_reg);

    logic [SumW-1:0] rx_sh, ry_sh, divisor;
    assign divisor = SumW'(WINDOW_SIZE - 2);
    assign rx_sh = {rx_reg[SumW-2:0], dx_reg[SumW-1]};
    assign ry_sh = {ry_reg[SumW-2:0], dy_reg[SumW-1]};

    logic signed [15:0] qx, qy;
    assign qx = nx_reg ? 16'(-dx_reg) : 16'(dx_reg);
    assign qy = ny_reg ? 16'(-dy_reg) : 16'(dy_reg);

    // The quotients are complete and the output register is free.
    logic out_load;
    assign out_load = (state_reg == T_DIV) && (dcnt_reg == 5'(SumW + 1))
                      && (!out_valid || out_acc);

    assign in_stall = (state_reg != T_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            lo_x_reg  <= '0;
            hi_x_reg  <= '0;
            lo_y_reg  <= '0;
            hi_y_reg  <= '0;
            count_reg <= '0;
            dcnt_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid <= 1'b1;
            else if (out_acc)
                out_valid <= 1'b0;
            case (state_reg)
                T_IDLE:
                    if (in_acc)
                        state_reg <= T_WORK;
                T_WORK:
                    if (cx.done)
                    begin
                        if (count_reg == '0)
                        begin
                            lo_x_reg <= cx.angle;
                            hi_x_reg <= cx.angle;
                            lo_y_reg <= cy.angle;
                            hi_y_reg <= cy.angle;
                        end
                        else
                        begin
                            if (cx.angle < lo_x_reg) lo_x_reg <= cx.angle;
                            if (cx.angle > hi_x_reg) hi_x_reg <= cx.angle;
                            if (cy.angle < lo_y_reg) lo_y_reg <= cy.angle;
                            if (cy.angle > hi_y_reg) hi_y_reg <= cy.angle;
                        end
                        sum_x_reg <= sum_x_reg + SumW'(cx.angle);
                        sum_y_reg <= sum_y_reg + SumW'(cy.angle);
                        if (count_reg == CntW'(WINDOW_SIZE - 1))
                        begin
                            count_reg <= '0;
                            dcnt_reg  <= '0;
                            state_reg <= T_DIV;
                        end
                        else
                        begin
                            count_reg <= count_reg + CntW'(1);
                            state_reg <= T_IDLE;
                        end
                    end
                T_DIV:
                    if (dcnt_reg == 5'd0)
                        dcnt_reg <= 5'd1;
                    else if (dcnt_reg == 5'(SumW + 1))
                    begin
                        if (out_load)
                        begin
                            sum_x_reg <= '0;
                            sum_y_reg <= '0;
                            lo_x_reg  <= '0;
                            hi_x_reg  <= '0;
                            lo_y_reg  <= '0;
                            hi_y_reg  <= '0;
                            state_reg <= T_IDLE;
                        end
                    end
                    else
                        dcnt_reg <= dcnt_reg + 5'd1;
                T_HOLD:
                    state_reg <= T_IDLE;
                default:
                    state_reg <= T_IDLE;
            endcase
        end
    end

    // Division datapath and result words.
    always_ff @(posedge clk)
    begin
        if (state_reg == T_DIV)
        begin
            if (dcnt_reg == 5'd0)
            begin
                nx_reg <= tx_sum[SumW-1];
                ny_reg <= ty_sum[SumW-1];
                dx_reg <= tx_sum[SumW-1] ? SumW'(-tx_sum) : SumW'(tx_sum);
                dy_reg <= ty_sum[SumW-1] ? SumW'(-ty_sum) : SumW'(ty_sum);
                rx_reg <= '0;
                ry_reg <= '0;
            end
            else if (dcnt_reg <= 5'(SumW))
            begin
                dx_reg <= {dx_reg[SumW-2:0], rx_sh >= divisor};
                rx_reg <= (rx_sh >= divisor) ? rx_sh - divisor : rx_sh;
                dy_reg <= {dy_reg[SumW-2:0], ry_sh >= divisor};
                ry_reg <= (ry_sh >= divisor) ? ry_sh - divisor : ry_sh;
            end
            if (out_load)
            begin
                tilt_x_mean <= qx;
                tilt_y_mean <= qy;
            end
        end
    end

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != T_IDLE) |-> in_stall) else $error("word taken while busy");
    a_units_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        cx.done == cy.done) else $error("tilt units out of step");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CntW'(WINDOW_SIZE)) else $error("sample count overran");
`endif

endmodule
